FILE: rtl/qrm_pkg.sv
// ----------------------------------------------------------------------------
// qrm_pkg: shared definitions for the queue with running maximum
// Default sizes, operation and status codes, and the control word that the
// top level hands to every candidate cell.
// ----------------------------------------------------------------------------
package qrm_pkg;

	// default sizes
	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	// operation codes carried by the kind field
	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_POP  = 1'b1;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_POP_EMPTY = 2'd1,
		ST_PUSH_FULL = 2'd2
	} status_t;

	// per-cycle command to the candidate cells
	typedef struct packed {
		logic push;   // insert the pushed value, drop smaller or equal tail entries
		logic shift;  // move every entry one cell toward the front
	} cell_ctl_t;

endpackage

FILE: rtl/qrm_in_if.sv
// ----------------------------------------------------------------------------
// qrm_in_if: request channel of the queue with running maximum
// Carries one operation item: push of a signed value or pop of the front.
// ----------------------------------------------------------------------------
interface qrm_in_if #(
	parameter int DATA_WIDTH = qrm_pkg::DATA_WIDTH_DEF
);
	logic                  valid;
	logic                  ready;
	logic                  kind;
	logic [DATA_WIDTH-1:0] value;

	modport source (output valid, output kind, output value, input ready);
	modport sink   (input valid, input kind, input value, output ready);
endinterface

FILE: rtl/qrm_out_if.sv
// ----------------------------------------------------------------------------
// qrm_out_if: result channel of the queue with running maximum
// Carries one result item per operation: maximum, empty flag, count, status.
// ----------------------------------------------------------------------------
interface qrm_out_if #(
	parameter int DATA_WIDTH = qrm_pkg::DATA_WIDTH_DEF,
	parameter int CNT_W      = $clog2(qrm_pkg::DEPTH_DEF + 1)
);
	logic                  valid;
	logic                  ready;
	logic [DATA_WIDTH-1:0] max_value;
	logic                  queue_empty;
	logic [CNT_W-1:0]      item_count;
	logic [1:0]            status;

	modport source (output valid, output max_value, output queue_empty,
		output item_count, output status, input ready);
	modport sink   (input valid, input max_value, input queue_empty,
		input item_count, input status, output ready);
endinterface

FILE: rtl/qrm_cell.sv
// ----------------------------------------------------------------------------
// qrm_cell: one candidate slot of the running-maximum list
// Holds a value and its arrival tag. On a push it keeps its entry only if the
// entry is larger than the pushed value, and takes the pushed value when it
// is the first slot not kept. On a shift it loads its back neighbor.
// ----------------------------------------------------------------------------
module qrm_cell #(
	parameter int DATA_WIDTH = qrm_pkg::DATA_WIDTH_DEF,
	parameter int SEQ_W      = $clog2(2 * qrm_pkg::DEPTH_DEF)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  qrm_pkg::cell_ctl_t    ctl,
	input  logic [DATA_WIDTH-1:0] push_value,
	input  logic [SEQ_W-1:0]      push_tag,
	input  logic                  prev_keep,
	input  logic                  nxt_valid,
	input  logic [DATA_WIDTH-1:0] nxt_value,
	input  logic [SEQ_W-1:0]      nxt_tag,
	output logic                  keep,
	output logic                  valid,
	output logic [DATA_WIDTH-1:0] value,
	output logic [SEQ_W-1:0]      tag
);
	import qrm_pkg::*;

	logic                  valid_q;
	logic [DATA_WIDTH-1:0] value_q;
	logic [SEQ_W-1:0]      tag_q;
	logic                  take;

	// keep a strictly larger entry; the first slot not kept takes the new value
	assign keep = valid_q && ($signed(push_value) < $signed(value_q));
	assign take = !keep && prev_keep;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.push) begin
			valid_q <= keep || take;
		end else if (ctl.shift) begin
			valid_q <= nxt_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			if (take) begin
				value_q <= push_value;
				tag_q   <= push_tag;
			end
		end else if (ctl.shift) begin
			value_q <= nxt_value;
			tag_q   <= nxt_tag;
		end
	end

	assign valid = valid_q;
	assign value = value_q;
	assign tag   = tag_q;

endmodule

FILE: rtl/queue_with_running_max.sv
// ----------------------------------------------------------------------------
// queue_with_running_max: FIFO that reports its largest held value
// Top level: item count, sequence counters, the row of candidate cells and
// the result register.
// ----------------------------------------------------------------------------
// Each request item pushes a signed value at the back or pops the front, and
// yields exactly one result item: the largest value still held (0 when
// empty), an empty flag, the item count and a status (pop on empty and push
// on full change nothing and are flagged). Only the count of queued items is
// stored; the maximum comes from a row of DEPTH candidate cells kept in
// strictly decreasing order. Every cell compares the pushed value against its
// own entry in the same cycle, and a pop of the item that owns the front cell
// shifts the row by one cell, so an item is accepted every clock cycle while
// the result side takes results; a stalled result holds the request side.
// ----------------------------------------------------------------------------
module queue_with_running_max #(
	parameter int DEPTH      = qrm_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = qrm_pkg::DATA_WIDTH_DEF
) (
	input logic      clk,
	input logic      arst_n,
	qrm_in_if.sink   req,
	qrm_out_if.source rsp
);
	import qrm_pkg::*;

	localparam int SEQ_W = $clog2(2 * DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0] held_q;
	logic [SEQ_W-1:0] head_q;
	logic [SEQ_W-1:0] tail_q;
	logic             out_valid_q;
	status_t          status_q;

	logic      accept;
	logic      is_pop;
	logic      push_ok;
	logic      pop_ok;
	cell_ctl_t ctl;

	logic                  keep_w  [DEPTH];
	logic                  valid_w [DEPTH];
	logic [DATA_WIDTH-1:0] value_w [DEPTH];
	logic [SEQ_W-1:0]      tag_w   [DEPTH];

	function automatic logic [SEQ_W-1:0] seq_next(input logic [SEQ_W-1:0] s);
		return (s == SEQ_W'(2 * DEPTH - 1)) ? '0 : s + 1'b1;
	endfunction

	// accept a request whenever the result register is free or being taken
	assign req.ready = !out_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign is_pop    = (req.kind == KIND_POP);
	assign push_ok   = accept && !is_pop && (held_q != CNT_W'(DEPTH));
	assign pop_ok    = accept && is_pop && (held_q != '0);

	// drop the front candidate only when it belongs to the front item
	always_comb begin
		ctl.push  = push_ok;
		ctl.shift = pop_ok && valid_w[0] && (tag_w[0] == head_q);
	end

	// candidate row
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                  prev_keep;
		logic                  nxt_valid;
		logic [DATA_WIDTH-1:0] nxt_value;
		logic [SEQ_W-1:0]      nxt_tag;

		if (i == 0) begin : g_front
			assign prev_keep = 1'b1;
		end else begin : g_mid
			assign prev_keep = keep_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_back
			assign nxt_valid = 1'b0;
			assign nxt_value = '0;
			assign nxt_tag   = '0;
		end else begin : g_link
			assign nxt_valid = valid_w[i+1];
			assign nxt_value = value_w[i+1];
			assign nxt_tag   = tag_w[i+1];
		end

		qrm_cell #(
			.DATA_WIDTH(DATA_WIDTH),
			.SEQ_W     (SEQ_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.push_value(req.value),
			.push_tag  (tail_q),
			.prev_keep (prev_keep),
			.nxt_valid (nxt_valid),
			.nxt_value (nxt_value),
			.nxt_tag   (nxt_tag),
			.keep      (keep_w[i]),
			.valid     (valid_w[i]),
			.value     (value_w[i]),
			.tag       (tag_w[i])
		);
	end

	// advance counters and hold the result status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
		end else begin
			if (push_ok) begin
				held_q <= held_q + 1'b1;
				tail_q <= seq_next(tail_q);
			end else if (pop_ok) begin
				held_q <= held_q - 1'b1;
				head_q <= seq_next(head_q);
			end

			if (accept) begin
				out_valid_q <= 1'b1;
				if (is_pop && !pop_ok) begin
					status_q <= ST_POP_EMPTY;
				end else if (!is_pop && !push_ok) begin
					status_q <= ST_PUSH_FULL;
				end else begin
					status_q <= ST_OK;
				end
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// state only moves when the pending result is taken, so read it directly
	assign rsp.valid       = out_valid_q;
	assign rsp.max_value   = ((held_q != '0) && valid_w[0]) ? value_w[0] : '0;
	assign rsp.queue_empty = (held_q == '0);
	assign rsp.item_count  = held_q;
	assign rsp.status      = status_q;

endmodule
